>>> sv/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared constants for the triangle face normal block: coordinate width,
// normalization precision, triangle corner count and result status codes.
// ----------------------------------------------------------------------------
package tfn_pkg;

	// internal coordinate width after sign extension
	localparam int CoordW = 32;
	// significant bits kept on the largest cross component before normalizing
	localparam int KeepBits = 30;
	// corner count of a valid face
	localparam logic [3:0] TriCorners = 4'd3;

	// result status codes
	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_NONTRI = 2'd1;
	localparam logic [1:0] STATUS_DEGEN  = 2'd2;

endpackage

>>> sv/tfn_isqrt.sv
// ----------------------------------------------------------------------------
// tfn_isqrt
// Fully pipelined floor square root of a 62-bit radicand, one result bit per
// stage, with a side payload carried alongside.
// ----------------------------------------------------------------------------
module tfn_isqrt #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [61:0]       in_rad,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [31:0]       out_root,
	output logic [SIDE_W-1:0] out_side
);

	localparam int Steps = 31;

	logic              v_q    [Steps+1];
	logic [63:0]       x_q    [Steps+1];
	logic [63:0]       r_q    [Steps+1];
	logic [SIDE_W-1:0] side_q [Steps+1];

	// entry register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0]    <= 64'(in_rad);
			r_q[0]    <= '0;
			side_q[0] <= in_side;
		end
	end

	// one digit-recurrence step per stage
	for (genvar j = 0; j < Steps; j++) begin : g_step
		localparam logic [63:0] Bit = 64'(1) << (2 * (Steps - 1 - j));
		logic [63:0] trial;
		logic [63:0] x_nx;
		logic [63:0] r_nx;

		always_comb begin
			trial = r_q[j] + Bit;
			if (x_q[j] >= trial) begin
				x_nx = x_q[j] - trial;
				r_nx = (r_q[j] >> 1) + Bit;
			end else begin
				x_nx = x_q[j];
				r_nx = r_q[j] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[j+1] <= 1'b0;
			end else if (en) begin
				v_q[j+1] <= v_q[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_q[j+1]    <= x_nx;
				r_q[j+1]    <= r_nx;
				side_q[j+1] <= side_q[j];
			end
		end
	end

	assign out_valid = v_q[Steps];
	assign out_root  = r_q[Steps][31:0];
	assign out_side  = side_q[Steps];

endmodule

>>> sv/tfn_div.sv
// ----------------------------------------------------------------------------
// tfn_div
// Three-lane pipelined restoring divider: q = (m * 32768 + len / 2) / len for
// each lane, 16 quotient bits, one bit per stage, side payload alongside.
// ----------------------------------------------------------------------------
module tfn_div #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [29:0]       in_mag  [3],
	input  logic [31:0]       in_len,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [15:0]       out_quo [3],
	output logic [SIDE_W-1:0] out_side
);

	localparam int QBits = 16;

	logic              v_q    [QBits+1];
	logic [47:0]       rem_q  [QBits+1][3];
	logic [15:0]       quo_q  [QBits+1][3];
	logic [31:0]       den_q  [QBits+1];
	logic [SIDE_W-1:0] side_q [QBits+1];

	// entry register: rounded numerator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rem_q[0][i] <= {3'b000, in_mag[i], 15'd0} + 48'(in_len >> 1);
				quo_q[0][i] <= '0;
			end
			den_q[0]  <= in_len;
			side_q[0] <= in_side;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < QBits; k++) begin : g_step
		localparam int Sh = QBits - 1 - k;
		logic [47:0] cmp;
		logic [47:0] rem_nx [3];
		logic [15:0] quo_nx [3];

		always_comb begin
			cmp = 48'(den_q[k]) << Sh;
			for (int i = 0; i < 3; i++) begin
				rem_nx[i] = rem_q[k][i];
				quo_nx[i] = quo_q[k][i];
				if (rem_q[k][i] >= cmp) begin
					rem_nx[i]     = rem_q[k][i] - cmp;
					quo_nx[i][Sh] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1]  <= rem_nx;
				quo_q[k+1]  <= quo_nx;
				den_q[k+1]  <= den_q[k];
				side_q[k+1] <= side_q[k];
			end
		end
	end

	assign out_valid = v_q[QBits];
	assign out_quo   = quo_q[QBits];
	assign out_side  = side_q[QBits];

endmodule

>>> sv/triangle_face_normal.sv
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal with winding correction for triangles from a vertex store.
// ----------------------------------------------------------------------------
// One transaction per cycle in both directions while the output is free.
// Vertex writes (op 0) land in the store at acceptance and give no result;
// a face (op 1) gives one result, in order of acceptance. The rate is set
// by the fully pipelined datapath: three copies of the vertex store give the
// three corner reads each cycle, the square root runs 31 bit-stages and the
// divider 16 bit-stages, all sharing one pipeline enable that holds every
// stage while a result waits on a stalled output. Corners outside the store
// read as the origin; vertex writes outside the store are dropped.
module triangle_face_normal #(
	parameter int VERTEX_COUNT = 4096,
	parameter int COORD_WIDTH  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [11:0]        vertex_index,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic [11:0]        corner_a,
	input  logic [11:0]        corner_b,
	input  logic [11:0]        corner_c,
	input  logic [3:0]         face_size,
	input  logic               last_face,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic               clockwise,
	output logic [1:0]         status,
	output logic               end_of_mesh
);

	import tfn_pkg::*;

	localparam int EffW  = (COORD_WIDTH < CoordW) ? COORD_WIDTH : CoordW;
	localparam int EntW  = 3 * EffW;
	localparam int AddrW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
	localparam int IdxW  = (AddrW > 12) ? AddrW : 12;
	localparam int SqSideW  = 1 + 2 + 1 + 3 + 3 * KeepBits;
	localparam int DivSideW = 1 + 2 + 1 + 3;

	// pipeline enable: move when the output register is free or being taken
	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	logic accept;
	assign accept = in_valid && adv;

	// vertex store, three copies for three read ports
	logic [EntW-1:0] store0 [VERTEX_COUNT];
	logic [EntW-1:0] store1 [VERTEX_COUNT];
	logic [EntW-1:0] store2 [VERTEX_COUNT];

	logic [IdxW-1:0] widx, ia, ib, ic;
	logic            wr_en;
	logic [EntW-1:0] wdata;

	assign widx  = IdxW'(vertex_index);
	assign ia    = IdxW'(corner_a);
	assign ib    = IdxW'(corner_b);
	assign ic    = IdxW'(corner_c);
	assign wr_en = accept && !op && (32'(vertex_index) < VERTEX_COUNT);
	assign wdata = {coord_z[EffW-1:0], coord_y[EffW-1:0], coord_x[EffW-1:0]};

	logic [EntW-1:0] rd_s1 [3];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store0[widx[AddrW-1:0]] <= wdata;
			store1[widx[AddrW-1:0]] <= wdata;
			store2[widx[AddrW-1:0]] <= wdata;
		end
		if (adv) begin
			rd_s1[0] <= store0[ia[AddrW-1:0]];
			rd_s1[1] <= store1[ib[AddrW-1:0]];
			rd_s1[2] <= store2[ic[AddrW-1:0]];
		end
	end

	// stage 1 control
	logic       v_s1, last_s1, nontri_s1;
	logic [2:0] rng_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept && op;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1   <= last_face;
			nontri_s1 <= (face_size != TriCorners);
			rng_s1[0] <= (32'(corner_a) < VERTEX_COUNT);
			rng_s1[1] <= (32'(corner_b) < VERTEX_COUNT);
			rng_s1[2] <= (32'(corner_c) < VERTEX_COUNT);
		end
	end

	// unpack corners, sign-extend, out-of-range corners read the origin
	logic signed [CoordW-1:0] pt [3][3];

	always_comb begin
		logic signed [EffW-1:0] t;
		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < 3; k++) begin
				t = rd_s1[c][EffW*k +: EffW];
				pt[c][k] = rng_s1[c] ? CoordW'(t) : '0;
			end
		end
	end

	// stage 2: edges and products for b x c
	logic                     v_s2, last_s2, nontri_s2;
	logic signed [CoordW:0]   e1_s2 [3];
	logic signed [CoordW:0]   e2_s2 [3];
	logic signed [CoordW-1:0] a_s2  [3];
	logic signed [63:0]       bcp_s2 [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2   <= last_s1;
			nontri_s2 <= nontri_s1;
			for (int k = 0; k < 3; k++) begin
				e1_s2[k] <= (CoordW+1)'(pt[1][k]) - (CoordW+1)'(pt[0][k]);
				e2_s2[k] <= (CoordW+1)'(pt[2][k]) - (CoordW+1)'(pt[0][k]);
				a_s2[k]  <= pt[0][k];
			end
			bcp_s2[0] <= pt[1][1] * pt[2][2];
			bcp_s2[1] <= pt[1][2] * pt[2][1];
			bcp_s2[2] <= pt[1][2] * pt[2][0];
			bcp_s2[3] <= pt[1][0] * pt[2][2];
			bcp_s2[4] <= pt[1][0] * pt[2][1];
			bcp_s2[5] <= pt[1][1] * pt[2][0];
		end
	end

	// stage 3: cross product terms, b x c wraps to 64 bits
	logic                     v_s3, last_s3, nontri_s3;
	logic signed [65:0]       xp_s3 [6];
	logic signed [63:0]       bc_s3 [3];
	logic signed [CoordW-1:0] a_s3  [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s3   <= last_s2;
			nontri_s3 <= nontri_s2;
			a_s3      <= a_s2;
			xp_s3[0]  <= e1_s2[1] * e2_s2[2];
			xp_s3[1]  <= e1_s2[2] * e2_s2[1];
			xp_s3[2]  <= e1_s2[2] * e2_s2[0];
			xp_s3[3]  <= e1_s2[0] * e2_s2[2];
			xp_s3[4]  <= e1_s2[0] * e2_s2[1];
			xp_s3[5]  <= e1_s2[1] * e2_s2[0];
			for (int k = 0; k < 3; k++) begin
				bc_s3[k] <= bcp_s2[2*k] - bcp_s2[2*k+1];
			end
		end
	end

	// stage 4: cross components, determinant partial products
	logic               v_s4, last_s4, nontri_s4;
	logic signed [66:0] cr_s4 [3];
	logic signed [63:0] dh_s4 [3];
	logic signed [64:0] dl_s4 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s4   <= last_s3;
			nontri_s4 <= nontri_s3;
			for (int k = 0; k < 3; k++) begin
				cr_s4[k] <= 67'(xp_s3[2*k]) - 67'(xp_s3[2*k+1]);
				dh_s4[k] <= a_s3[k] * $signed(bc_s3[k][63:32]);
				dl_s4[k] <= a_s3[k] * $signed({1'b0, bc_s3[k][31:0]});
			end
		end
	end

	// stage 5: magnitudes, degenerate test, determinant terms
	logic               v_s5, last_s5;
	logic [1:0]         st_s5;
	logic [66:0]        mg_s5  [3];
	logic [2:0]         neg_s5;
	logic signed [97:0] dt_s5  [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s5 <= last_s4;
			if (nontri_s4) begin
				st_s5 <= STATUS_NONTRI;
			end else if (cr_s4[0] == 0 && cr_s4[1] == 0 && cr_s4[2] == 0) begin
				st_s5 <= STATUS_DEGEN;
			end else begin
				st_s5 <= STATUS_OK;
			end
			for (int k = 0; k < 3; k++) begin
				neg_s5[k] <= cr_s4[k][66];
				mg_s5[k]  <= cr_s4[k][66] ? 67'(-cr_s4[k]) : 67'(cr_s4[k]);
				dt_s5[k]  <= (98'(dh_s4[k]) <<< 32) + 98'(dl_s4[k]);
			end
		end
	end

	// stage 6: normalizing shift from the widest magnitude, determinant sign
	logic        v_s6, last_s6, cw_s6;
	logic [1:0]  st_s6;
	logic [66:0] mg_s6 [3];
	logic [2:0]  neg_s6;
	logic [6:0]  sh_s6;
	logic [66:0] mg_or;
	logic [6:0]  blen;
	logic [99:0] det_sum;

	always_comb begin
		mg_or = mg_s5[0] | mg_s5[1] | mg_s5[2];
		blen  = '0;
		for (int i = 0; i < 67; i++) begin
			if (mg_or[i]) begin
				blen = 7'(i + 1);
			end
		end
		det_sum = 100'(dt_s5[0]) + 100'(dt_s5[1]) + 100'(dt_s5[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s6 <= last_s5;
			st_s6   <= st_s5;
			mg_s6   <= mg_s5;
			neg_s6  <= neg_s5;
			cw_s6   <= det_sum[99];
			sh_s6   <= (blen > 7'(KeepBits)) ? blen - 7'(KeepBits) : 7'd0;
		end
	end

	// stage 7: shifted magnitudes
	logic                v_s7, last_s7, cw_s7;
	logic [1:0]          st_s7;
	logic [2:0]          neg_s7;
	logic [KeepBits-1:0] sm_s7 [3];
	logic [66:0]         shd   [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			shd[k] = mg_s6[k] >> sh_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s7 <= last_s6;
			st_s7   <= st_s6;
			cw_s7   <= cw_s6;
			neg_s7  <= neg_s6;
			for (int k = 0; k < 3; k++) begin
				sm_s7[k] <= shd[k][KeepBits-1:0];
			end
		end
	end

	// stage 8: squares
	logic                  v_s8, last_s8, cw_s8;
	logic [1:0]            st_s8;
	logic [2:0]            neg_s8;
	logic [KeepBits-1:0]   sm_s8 [3];
	logic [2*KeepBits-1:0] sq_s8 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s8 <= last_s7;
			st_s8   <= st_s7;
			cw_s8   <= cw_s7;
			neg_s8  <= neg_s7;
			sm_s8   <= sm_s7;
			for (int k = 0; k < 3; k++) begin
				sq_s8[k] <= sm_s7[k] * sm_s7[k];
			end
		end
	end

	// stage 9: sum of squares
	logic               v_s9;
	logic [61:0]        sum_s9;
	logic [SqSideW-1:0] side_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s9  <= 62'(sq_s8[0]) + 62'(sq_s8[1]) + 62'(sq_s8[2]);
			side_s9 <= {last_s8, st_s8, cw_s8, neg_s8, sm_s8[2], sm_s8[1], sm_s8[0]};
		end
	end

	// vector length
	logic               sq_valid;
	logic [31:0]        sq_root;
	logic [SqSideW-1:0] sq_side;

	tfn_isqrt #(
		.SIDE_W (SqSideW)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s9),
		.in_rad    (sum_s9),
		.in_side   (side_s9),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// per-component scaling to Q1.15
	logic [KeepBits-1:0] dv_mag [3];
	logic [15:0]         dv_quo [3];
	logic                dv_valid;
	logic [DivSideW-1:0] dv_side;

	assign dv_mag[0] = sq_side[KeepBits-1:0];
	assign dv_mag[1] = sq_side[2*KeepBits-1:KeepBits];
	assign dv_mag[2] = sq_side[3*KeepBits-1:2*KeepBits];

	tfn_div #(
		.SIDE_W (DivSideW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (sq_valid),
		.in_mag    (dv_mag),
		.in_len    (sq_root),
		.in_side   (sq_side[SqSideW-1:3*KeepBits]),
		.out_valid (dv_valid),
		.out_quo   (dv_quo),
		.out_side  (dv_side)
	);

	// saturate, apply signs, mask rejected faces
	logic [2:0]         f_neg;
	logic               f_cw, f_last;
	logic [1:0]         f_st;
	logic signed [15:0] f_n [3];

	assign {f_last, f_st, f_cw, f_neg} = dv_side;

	always_comb begin
		logic [15:0] m;
		for (int k = 0; k < 3; k++) begin
			m = (dv_quo[k] > 16'd32767) ? 16'd32767 : dv_quo[k];
			f_n[k] = (f_neg[k] ^ f_cw) ? -$signed(m) : $signed(m);
			if (f_st != STATUS_OK) begin
				f_n[k] = '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			normal_x    <= f_n[0];
			normal_y    <= f_n[1];
			normal_z    <= f_n[2];
			clockwise   <= (f_st == STATUS_OK) && f_cw;
			status      <= f_st;
			end_of_mesh <= f_last;
		end
	end

endmodule

>>> sv/tfn_checker.sv
// ----------------------------------------------------------------------------
// tfn_checker
// Port-level checks on the result channel of triangle_face_normal.
// ----------------------------------------------------------------------------
module tfn_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] normal_x,
	input logic signed [15:0] normal_y,
	input logic signed [15:0] normal_z,
	input logic               clockwise,
	input logic [1:0]         status
);

	import tfn_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(normal_x) && $stable(normal_y)
			&& $stable(normal_z) && $stable(status) && $stable(clockwise))
		else $error("stalled result changed");

	// rejected faces carry a zero normal and no flip
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STATUS_OK |-> normal_x == 0 && normal_y == 0
			&& normal_z == 0 && !clockwise)
		else $error("rejected face with nonzero normal");

	// only defined status codes
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == STATUS_OK || status == STATUS_NONTRI
			|| status == STATUS_DEGEN)
		else $error("undefined status");

	// saturation keeps components symmetric
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_x != 16'h8000 && normal_y != 16'h8000
			&& normal_z != 16'h8000)
		else $error("normal component out of range");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (.*);

>>> tb/triangle_face_normal_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_face_normal_tb
// Self-checking bench for the triangle face normal block. Vertex writes fill
// a shadow store, and each face transaction is predicted with exact wide
// integer arithmetic. A scoreboard checks every result field in order, while
// sender and receiver idle at random, then, after a drain pause, with no idling
// and a long output hold-off.
// ----------------------------------------------------------------------------
module triangle_face_normal_tb;
	import tfn_pkg::*;

	localparam int IDX_LIMIT   = 4096;
	localparam int RANDOM_ITEMS = 800;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 100;
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_FACE  = 1'b1;

	typedef struct {
		logic        op;
		logic [11:0] vi;
		logic [31:0] x, y, z;
		logic [11:0] ca, cb, cc;
		logic [3:0]  fs;
		logic        lf;
	} mesh_item_t;

	typedef struct {
		logic [15:0] nx, ny, nz;
		logic        cw;
		logic [1:0]  st;
		logic        eom;
	} face_normal_t;

	// shadow vertex store, prediction and in-order checking
	class normal_scoreboard;
		logic signed [31:0] vx [IDX_LIMIT];
		logic signed [31:0] vy [IDX_LIMIT];
		logic signed [31:0] vz [IDX_LIMIT];
		face_normal_t expected_normals[$];
		int errors;
		int n_ok, n_cw, n_nontri, n_degen, n_writes;

		function automatic logic [63:0] floor_sqrt(logic [63:0] v);
			logic [63:0] r, t;
			r = 0;
			for (int b = 31; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= v) r = t;
			end
			return r;
		endfunction

		function automatic face_normal_t predict_face(mesh_item_t it);
			face_normal_t res;
			logic signed [63:0]  p [3][3];
			logic signed [63:0]  e1 [3], e2 [3];
			logic signed [127:0] cr [3], bc [3], det;
			logic [127:0] mg [3];
			logic [63:0]  sm [3], sum, len, q;
			logic signed [15:0] s;
			int maxlen, shift;
			logic [11:0] idx [3];
			res = '{default: '0};
			res.eom = it.lf;
			if (it.fs != TriCorners) begin
				res.st = STATUS_NONTRI;
				return res;
			end
			idx[0] = it.ca; idx[1] = it.cb; idx[2] = it.cc;
			for (int k = 0; k < 3; k++) begin
				p[k][0] = vx[idx[k]]; p[k][1] = vy[idx[k]]; p[k][2] = vz[idx[k]];
			end
			for (int i = 0; i < 3; i++) begin
				e1[i] = p[1][i] - p[0][i];
				e2[i] = p[2][i] - p[0][i];
			end
			cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
			cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
			cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
			if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
				res.st = STATUS_DEGEN;
				return res;
			end
			bc[0] = p[1][1] * p[2][2] - p[1][2] * p[2][1];
			bc[1] = p[1][2] * p[2][0] - p[1][0] * p[2][2];
			bc[2] = p[1][0] * p[2][1] - p[1][1] * p[2][0];
			det = p[0][0] * bc[0] + p[0][1] * bc[1] + p[0][2] * bc[2];
			res.cw = det < 0;
			res.st = STATUS_OK;
			// common shift so the largest magnitude keeps KeepBits bits
			maxlen = 0;
			for (int i = 0; i < 3; i++) begin
				mg[i] = cr[i] < 0 ? -cr[i] : cr[i];
				for (int b = 127; b >= 0; b--)
					if (mg[i][b]) begin
						if (b + 1 > maxlen) maxlen = b + 1;
						break;
					end
			end
			shift = maxlen > KeepBits ? maxlen - KeepBits : 0;
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				sm[i] = 64'(mg[i] >> shift);
				sum += sm[i] * sm[i];
			end
			len = floor_sqrt(sum);
			for (int i = 0; i < 3; i++) begin
				q = (sm[i] * 64'd32768 + len / 2) / len;
				if (q > 64'd32767) q = 64'd32767;
				s = q[15:0];
				if (cr[i] < 0) s = -s;
				if (res.cw) s = -s;
				if (i == 0) res.nx = s;
				else if (i == 1) res.ny = s;
				else res.nz = s;
			end
			return res;
		endfunction

		function void log_accepted(mesh_item_t it);
			face_normal_t res;
			if (it.op == OP_WRITE) begin
				vx[it.vi] = it.x; vy[it.vi] = it.y; vz[it.vi] = it.z;
				n_writes++;
				return;
			end
			res = predict_face(it);
			case (res.st)
				STATUS_NONTRI: n_nontri++;
				STATUS_DEGEN:  n_degen++;
				default: begin
					n_ok++;
					if (res.cw) n_cw++;
				end
			endcase
			expected_normals.push_back(res);
		endfunction

		function void check_normal(face_normal_t got);
			face_normal_t want;
			if (expected_normals.size() == 0) begin
				$error("result with no face transaction pending");
				errors++;
				return;
			end
			want = expected_normals.pop_front();
			if (got.nx !== want.nx) begin
				$error("normal_x expected %0d got %0d", $signed(want.nx), $signed(got.nx));
				errors++;
			end
			if (got.ny !== want.ny) begin
				$error("normal_y expected %0d got %0d", $signed(want.ny), $signed(got.ny));
				errors++;
			end
			if (got.nz !== want.nz) begin
				$error("normal_z expected %0d got %0d", $signed(want.nz), $signed(got.nz));
				errors++;
			end
			if (got.cw !== want.cw) begin
				$error("clockwise expected %0d got %0d", want.cw, got.cw);
				errors++;
			end
			if (got.st !== want.st) begin
				$error("status expected %0d got %0d", want.st, got.st);
				errors++;
			end
			if (got.eom !== want.eom) begin
				$error("end_of_mesh expected %0d got %0d", want.eom, got.eom);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic op, last_face, clockwise, end_of_mesh;
	logic [11:0] vertex_index, corner_a, corner_b, corner_c;
	logic signed [31:0] coord_x, coord_y, coord_z;
	logic [3:0] face_size;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic [1:0] status;

	triangle_face_normal u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .vertex_index(vertex_index),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
		.face_size(face_size), .last_face(last_face),
		.out_valid(out_valid), .out_stall(out_stall),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.clockwise(clockwise), .status(status), .end_of_mesh(end_of_mesh)
	);

	normal_scoreboard sb = new();
	int send_idle_pct, recv_idle_pct, hold_left, quiet_cycles;
	logic [11:0] written_idx[$];

	// clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// monitor both channels and guard against a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.log_accepted('{op, vertex_index, coord_x, coord_y, coord_z,
					corner_a, corner_b, corner_c, face_size, last_face});
			if (out_valid && !out_stall)
				sb.check_normal('{normal_x, normal_y, normal_z, clockwise, status,
					end_of_mesh});
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// receiver: random stall, or a long counted hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// drive one transaction, idling first at random
	task automatic send_item(mesh_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= it.op; vertex_index <= it.vi;
		coord_x <= it.x; coord_y <= it.y; coord_z <= it.z;
		corner_a <= it.ca; corner_b <= it.cb; corner_c <= it.cc;
		face_size <= it.fs; last_face <= it.lf;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_vertex(logic [11:0] vi, logic [31:0] x, logic [31:0] y,
		logic [31:0] z);
		mesh_item_t it;
		it = '{OP_WRITE, vi, x, y, z, 12'($urandom), 12'($urandom), 12'($urandom),
			4'($urandom), 1'($urandom)};
		written_idx.push_back(vi);
		send_item(it);
	endtask

	task automatic send_face(logic [11:0] a, logic [11:0] b, logic [11:0] c,
		logic [3:0] fs, logic lf);
		mesh_item_t it;
		it = '{OP_FACE, 12'($urandom), $urandom, $urandom, $urandom, a, b, c, fs, lf};
		send_item(it);
	endtask

	function automatic logic [31:0] rand_coord();
		if ($urandom_range(2) == 0) return $urandom;
		return 32'($signed($urandom_range(2097152)) - 1048576);
	endfunction

	task automatic random_item();
		logic [11:0] a, b, c;
		logic [3:0] fs;
		if ($urandom_range(3) == 0)
			write_vertex(12'($urandom), rand_coord(), rand_coord(), rand_coord());
		else begin
			a = written_idx[$urandom_range(written_idx.size() - 1)];
			b = written_idx[$urandom_range(written_idx.size() - 1)];
			c = written_idx[$urandom_range(written_idx.size() - 1)];
			// occasional repeated corner for a zero-area face
			if ($urandom_range(9) == 0) c = a;
			fs = ($urandom_range(11) == 0) ? 4'($urandom) : TriCorners;
			send_face(a, b, c, fs, 1'($urandom));
		end
	endtask

	// stimulus
	initial begin
		arst_n = 1'b0; in_valid = 1'b0; out_stall = 1'b0;
		op = OP_WRITE; vertex_index = '0; coord_x = '0; coord_y = '0; coord_z = '0;
		corner_a = '0; corner_b = '0; corner_c = '0; face_size = '0; last_face = 1'b0;
		send_idle_pct = 37; recv_idle_pct = 62; hold_left = 0; quiet_cycles = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: unit axes, extremes, winding, rejects
		write_vertex(12'd0, 32'd0, 32'd0, 32'd0);
		write_vertex(12'd1, 32'd65536, 32'd0, 32'd0);
		write_vertex(12'd2, 32'd0, 32'd65536, 32'd0);
		write_vertex(12'd3, 32'd0, 32'd0, 32'd65536);
		write_vertex(12'd4095, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		write_vertex(12'd4, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		write_vertex(12'd5, 32'd131072, 32'd0, 32'd0);
		send_face(12'd1, 12'd2, 12'd3, TriCorners, 1'b0);
		send_face(12'd1, 12'd3, 12'd2, TriCorners, 1'b0);
		send_face(12'd0, 12'd1, 12'd2, TriCorners, 1'b0);
		send_face(12'd1, 12'd1, 12'd2, TriCorners, 1'b0);
		send_face(12'd0, 12'd1, 12'd5, TriCorners, 1'b0);
		send_face(12'd1, 12'd2, 12'd3, 4'd4, 1'b0);
		send_face(12'd1, 12'd2, 12'd3, 4'd0, 1'b0);
		send_face(12'd1, 12'd2, 12'd3, 4'd15, 1'b1);
		send_face(12'd4095, 12'd4, 12'd1, TriCorners, 1'b1);
		send_face(12'd4, 12'd4095, 12'd2, TriCorners, 1'b0);
		send_face(12'd4095, 12'd4, 12'd0, TriCorners, 1'b0);

		// random, receiver sparse side first
		repeat (RANDOM_ITEMS / 3) random_item();
		send_idle_pct = 62; recv_idle_pct = 37;
		repeat (RANDOM_ITEMS / 3) random_item();

		// sender pauses until everything has drained
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_normals.size() != 0) @(posedge clk);

		// no idling, with a long output hold-off to back up the pipeline
		send_idle_pct = 0; recv_idle_pct = 0;
		@(negedge clk);
		hold_left <= 400;
		repeat (RANDOM_ITEMS / 3) random_item();
		@(negedge clk);
		in_valid <= 1'b0;

		while (sb.expected_normals.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d vertex writes and %0d faces: %0d ok (%0d flipped),",
			sb.n_writes, sb.n_ok + sb.n_nontri + sb.n_degen, sb.n_ok, sb.n_cw);
		$display("  %0d non-triangle and %0d degenerate, under random and long stalls.",
			sb.n_nontri, sb.n_degen);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
